@@ sv/hrpc_pkg.sv @@
// ----------------------------------------------------------------------------
// hrpc_pkg
// Shared types, constants and helpers of the height relief palette colorizer.
// ----------------------------------------------------------------------------
package hrpc_pkg;

   localparam int EMBOSS_LAG_DEF = 3;
   localparam int MID_DEPTH_DEF  = 4;
   localparam int OUT_DEPTH_DEF  = 4;

   localparam int HEIGHT_W    = 8;
   localparam int ALPHA_W     = 8;
   localparam int CHAN_W      = 8;
   localparam int COLOR_W     = 24;
   localparam int NUM_CHAN    = 3;
   localparam int PAL_INDEX_W = 13;
   localparam int SHADE_W     = 4;
   localparam int LAND_BIT    = 8;
   localparam int HALF_ADDR_W = PAL_INDEX_W - 1;
   localparam int HALF_DEPTH  = 1 << HALF_ADDR_W;
   localparam int PROD_W      = 2 * CHAN_W;
   localparam int SUM_W       = PROD_W + 1;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 1;

   localparam logic [SHADE_W-1:0]  SHADE_MAX   = 4'd15;
   localparam logic [SHADE_W-1:0]  SHADE_FIXED = 4'd8;
   localparam logic signed [9:0]   FLAT_BIAS   = 10'sd8;
   localparam logic signed [9:0]   GLOBE_BIAS  = 10'sd16;
   localparam logic [ALPHA_W-1:0]  ALPHA_FULL  = 8'd255;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_PIXEL = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RELIEF_ENABLED  = 1'b0,
      CSR_FLAT_PROJECTION = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic relief_enabled;
      logic flat_projection;
   } cfg_type;

   // One queued command: either a palette write or a pixel lookup.
   typedef struct packed {
      logic                   pixel;
      logic                   land_sel;
      logic [HALF_ADDR_W-1:0] addr;
      logic [COLOR_W-1:0]     color;
      logic [ALPHA_W-1:0]     alpha;
   } cmd_type;

   // Exact floor(x / 255) for x up to 255 * 255.
   function automatic logic [CHAN_W-1:0] div255(input logic [SUM_W-1:0] x);
      logic [SUM_W-1:0] t;
      t = x + (x >> 8) + SUM_W'(1);
      return t[PROD_W-1:CHAN_W];
   endfunction

endpackage

@@ sv/hrpc_ram.sv @@
// ----------------------------------------------------------------------------
// hrpc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hrpc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/hrpc_fifo.sv @@
// ----------------------------------------------------------------------------
// hrpc_fifo
// Short register queue; the head entry is shown while the queue is not empty.
// ----------------------------------------------------------------------------
module hrpc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic                       full,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_wr, do_rd;

   assign do_wr = push && !full;
   assign do_rd = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = data_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CW'(DEPTH));
   assign count    = count_ff;

endmodule

@@ sv/hrpc_front.sv @@
// ----------------------------------------------------------------------------
// hrpc_front
// Accepts items, runs the height delay line and builds queued commands.
// ----------------------------------------------------------------------------
module hrpc_front #(
   parameter int EMBOSS_LAG = hrpc_pkg::EMBOSS_LAG_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  hrpc_pkg::cfg_type                  cfg,
   input  logic                               req_push,
   input  logic                               req_mode,
   input  logic [hrpc_pkg::PAL_INDEX_W-1:0]   req_palette_index,
   input  logic [hrpc_pkg::COLOR_W-1:0]       req_palette_color,
   input  logic [hrpc_pkg::HEIGHT_W-1:0]      req_height,
   input  logic [hrpc_pkg::ALPHA_W-1:0]       req_coast_alpha,
   input  logic                               req_line_start,
   input  logic                               req_frame_start,
   input  logic                               mid_full,
   output logic                               mid_push,
   output hrpc_pkg::cmd_type                  mid_cmd
);

   localparam int HW = hrpc_pkg::HEIGHT_W;

   logic [HW-1:0] delay_ff [EMBOSS_LAG];
   logic [HW-1:0] delay_in [EMBOSS_LAG];
   logic [HW-1:0] base     [EMBOSS_LAG];

   logic                          accept;
   logic                          is_pixel;
   logic                          clear;
   logic [HW-1:0]                 old_h;
   logic signed [9:0]             diff;
   logic signed [9:0]             level;
   logic [hrpc_pkg::SHADE_W-1:0]  shade;

   assign accept   = req_push && !mid_full;
   assign is_pixel = (req_mode == hrpc_pkg::MODE_PIXEL);
   assign clear    = cfg.flat_projection ? req_line_start : req_frame_start;

   always_comb begin
      for (int i = 0; i < EMBOSS_LAG; i++) begin
         base[i] = clear ? '0 : delay_ff[i];
      end
      old_h = base[0];

      if (cfg.flat_projection) begin
         diff  = $signed({2'b00, old_h}) + hrpc_pkg::FLAT_BIAS - $signed({2'b00, req_height});
         level = diff;
      end else begin
         diff  = $signed({2'b00, old_h}) + hrpc_pkg::GLOBE_BIAS - $signed({2'b00, req_height});
         level = (diff < 0) ? 10'sd0 : (diff >>> 1);
      end

      if (!cfg.relief_enabled) begin
         shade = hrpc_pkg::SHADE_FIXED;
      end else if (level < 0) begin
         shade = '0;
      end else if (level > $signed({6'b000000, hrpc_pkg::SHADE_MAX})) begin
         shade = hrpc_pkg::SHADE_MAX;
      end else begin
         shade = level[hrpc_pkg::SHADE_W-1:0];
      end

      // The line shifts only with relief on; clears apply either way.
      for (int i = 0; i < EMBOSS_LAG; i++) begin
         delay_in[i] = delay_ff[i];
      end
      if (accept && is_pixel) begin
         if (cfg.relief_enabled) begin
            for (int i = 0; i < EMBOSS_LAG - 1; i++) begin
               delay_in[i] = base[i + 1];
            end
            delay_in[EMBOSS_LAG-1] = req_height;
         end else begin
            for (int i = 0; i < EMBOSS_LAG; i++) begin
               delay_in[i] = base[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < EMBOSS_LAG; i++) begin
            delay_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < EMBOSS_LAG; i++) begin
            delay_ff[i] <= delay_in[i];
         end
      end
   end

   always_comb begin
      mid_cmd.pixel = is_pixel;
      mid_cmd.color = req_palette_color;
      mid_cmd.alpha = req_coast_alpha;
      if (is_pixel) begin
         mid_cmd.land_sel = 1'b0;
         mid_cmd.addr     = {shade, req_height};
      end else begin
         mid_cmd.land_sel = req_palette_index[hrpc_pkg::LAND_BIT];
         mid_cmd.addr     = {req_palette_index[hrpc_pkg::PAL_INDEX_W-1:hrpc_pkg::LAND_BIT+1],
                             req_palette_index[hrpc_pkg::LAND_BIT-1:0]};
      end
   end

   assign mid_push = accept;

endmodule

@@ sv/hrpc_back.sv @@
// ----------------------------------------------------------------------------
// hrpc_back
// Executes queued commands: palette writes, lookups, blend and result queue.
// ----------------------------------------------------------------------------
module hrpc_back #(
   parameter int OUT_DEPTH = hrpc_pkg::OUT_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          mid_empty,
   input  hrpc_pkg::cmd_type             mid_cmd,
   output logic                          mid_pop,
   input  logic                          rsp_pop,
   output logic                          rsp_empty,
   output logic [hrpc_pkg::COLOR_W-1:0]  rsp_pixel_color
);

   localparam int CW  = $clog2(OUT_DEPTH + 1);
   localparam int NC  = hrpc_pkg::NUM_CHAN;
   localparam int CHW = hrpc_pkg::CHAN_W;

   logic                          issue_ok;
   logic [CW:0]                   used;
   logic [CW-1:0]                 out_count;
   logic                          out_full;
   logic                          sea_we, land_we;
   logic [hrpc_pkg::COLOR_W-1:0]  sea_rd, land_rd;
   logic                          v1_ff, v1_in;
   logic [hrpc_pkg::ALPHA_W-1:0]  alpha1_ff;
   logic                          v2_ff;
   logic [hrpc_pkg::PROD_W-1:0]   pl_ff [NC];
   logic [hrpc_pkg::PROD_W-1:0]   ps_ff [NC];
   logic [hrpc_pkg::PROD_W-1:0]   pl_in [NC];
   logic [hrpc_pkg::PROD_W-1:0]   ps_in [NC];
   logic [hrpc_pkg::COLOR_W-1:0]  blend;
   logic [hrpc_pkg::ALPHA_W-1:0]  inv_alpha;

   // Pixels in flight hold a slot in the result queue before they issue.
   assign used     = {1'b0, out_count} + (CW+1)'(v1_ff) + (CW+1)'(v2_ff);
   assign issue_ok = (used < (CW+1)'(OUT_DEPTH));
   assign mid_pop  = !mid_empty && issue_ok;

   assign sea_we  = mid_pop && !mid_cmd.pixel && !mid_cmd.land_sel;
   assign land_we = mid_pop && !mid_cmd.pixel && mid_cmd.land_sel;
   assign v1_in   = mid_pop && mid_cmd.pixel;

   hrpc_ram #(
      .WIDTH (hrpc_pkg::COLOR_W),
      .DEPTH (hrpc_pkg::HALF_DEPTH)
   ) u_sea_ram (
      .clock   (clock),
      .wr_en   (sea_we),
      .wr_addr (mid_cmd.addr),
      .wr_data (mid_cmd.color),
      .rd_addr (mid_cmd.addr),
      .rd_data (sea_rd)
   );

   hrpc_ram #(
      .WIDTH (hrpc_pkg::COLOR_W),
      .DEPTH (hrpc_pkg::HALF_DEPTH)
   ) u_land_ram (
      .clock   (clock),
      .wr_en   (land_we),
      .wr_addr (mid_cmd.addr),
      .wr_data (mid_cmd.color),
      .rd_addr (mid_cmd.addr),
      .rd_data (land_rd)
   );

   assign inv_alpha = hrpc_pkg::ALPHA_FULL - alpha1_ff;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         pl_in[c] = {8'h00, alpha1_ff} * {8'h00, land_rd[c*CHW +: CHW]};
         ps_in[c] = {8'h00, inv_alpha} * {8'h00, sea_rd[c*CHW +: CHW]};
      end
      for (int c = 0; c < NC; c++) begin
         blend[c*CHW +: CHW] = hrpc_pkg::div255(hrpc_pkg::SUM_W'(pl_ff[c])
                                              + hrpc_pkg::SUM_W'(ps_ff[c]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      alpha1_ff <= mid_cmd.alpha;
      for (int c = 0; c < NC; c++) begin
         pl_ff[c] <= pl_in[c];
         ps_ff[c] <= ps_in[c];
      end
   end

   hrpc_fifo #(
      .WIDTH (hrpc_pkg::COLOR_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (v2_ff),
      .push_data (blend),
      .pop       (rsp_pop),
      .pop_data  (rsp_pixel_color),
      .empty     (rsp_empty),
      .full      (out_full),
      .count     (out_count)
   );

   // The credit check keeps the result queue from ever being pushed while full.
   logic unused_full;
   assign unused_full = out_full;

endmodule

@@ sv/height_relief_palette_colorizer_core.sv @@
// ----------------------------------------------------------------------------
// height_relief_palette_colorizer_core
// Colors a pixel stream from a height-shaded sea/land palette, blended by
// land coverage.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Moves
//  --------  -----------------  ------------------------------------------
//  req_      push / full        one item: palette load or pixel
//  rsp_      empty / pop        one item: blended 24-bit pixel color
//  csr_      valid / ready      register index and write data
//
// One item is accepted per clock while the command queue has room. A pixel
// item enters the command queue; it leaves the queue as both palette halves are
// read, then the per-channel products are registered, then their sum is
// divided by 255 and enters the result queue. A palette load is written at
// the edge that takes it out of the command queue and causes no result. Reset
// clears the delay line, the queues and the registers; the palette is undefined
// until loaded. A stalled result side fills the result queue, then the command
// queue, then raises req_full; csr_ready is always high.
//
// Structure: the front stage computes the shade level from the height delay
// line and turns each item into a command, a short command queue decouples it
// from the back stage, which owns the two palette RAMs (sea half and land half,
// split on column bit 8 so a pixel reads both in the same cycle) and the blend.
module height_relief_palette_colorizer_core #(
   parameter int EMBOSS_LAG = hrpc_pkg::EMBOSS_LAG_DEF,
   parameter int MID_DEPTH  = hrpc_pkg::MID_DEPTH_DEF,
   parameter int OUT_DEPTH  = hrpc_pkg::OUT_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic                               req_mode,
   input  logic [hrpc_pkg::PAL_INDEX_W-1:0]   req_palette_index,
   input  logic [hrpc_pkg::COLOR_W-1:0]       req_palette_color,
   input  logic [hrpc_pkg::HEIGHT_W-1:0]      req_height,
   input  logic [hrpc_pkg::ALPHA_W-1:0]       req_coast_alpha,
   input  logic                               req_line_start,
   input  logic                               req_frame_start,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [hrpc_pkg::COLOR_W-1:0]       rsp_pixel_color,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [hrpc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [hrpc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int MCW = $clog2(MID_DEPTH + 1);

   // Configuration registers. The user must write both only while the block is idle; the block does not enforce it.
   logic relief_ff, relief_in;
   logic flat_ff, flat_in;
   hrpc_pkg::cfg_type cfg;

   assign csr_ready = 1'b1;

   always_comb begin
      relief_in = relief_ff;
      flat_in   = flat_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            hrpc_pkg::CSR_RELIEF_ENABLED:  relief_in = csr_wdata[0];
            hrpc_pkg::CSR_FLAT_PROJECTION: flat_in   = csr_wdata[0];
            default: begin
               relief_in = relief_ff;
               flat_in   = flat_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         relief_ff <= 1'b1;
         flat_ff   <= 1'b0;
      end else begin
         relief_ff <= relief_in;
         flat_ff   <= flat_in;
      end
   end

   assign cfg.relief_enabled  = relief_ff;
   assign cfg.flat_projection = flat_ff;

   // Front stage: classify the item and compute its shade level.
   logic              mid_push, mid_pop, mid_empty, mid_full;
   logic [MCW-1:0]    mid_count;
   hrpc_pkg::cmd_type front_cmd, back_cmd;

   hrpc_front #(
      .EMBOSS_LAG (EMBOSS_LAG)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_push          (req_push),
      .req_mode          (req_mode),
      .req_palette_index (req_palette_index),
      .req_palette_color (req_palette_color),
      .req_height        (req_height),
      .req_coast_alpha   (req_coast_alpha),
      .req_line_start    (req_line_start),
      .req_frame_start   (req_frame_start),
      .mid_full          (mid_full),
      .mid_push          (mid_push),
      .mid_cmd           (front_cmd)
   );

   assign req_full = mid_full;

   // Command queue between the two stages.
   hrpc_fifo #(
      .WIDTH ($bits(hrpc_pkg::cmd_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (front_cmd),
      .pop       (mid_pop),
      .pop_data  (back_cmd),
      .empty     (mid_empty),
      .full      (mid_full),
      .count     (mid_count)
   );

   // Back stage: palette RAMs, blend and result queue.
   hrpc_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .mid_empty       (mid_empty),
      .mid_cmd         (back_cmd),
      .mid_pop         (mid_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pixel_color (rsp_pixel_color)
   );

   // Every accepted item enters the command queue in the same cycle.
   a_accept_enqueues: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |-> mid_push)
      else $error("accepted item did not enter the command queue");

   // The back stage never takes a command from an empty queue.
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      mid_pop |-> !mid_empty)
      else $error("command queue popped while empty");

   // The command queue occupancy stays within its depth.
   a_mid_count: assert property (@(posedge clock) disable iff (reset)
      mid_count <= MCW'(MID_DEPTH))
      else $error("command queue count out of range");

   // No result is shown right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("result shown right after reset");

endmodule
